[design/mixed_fraction_alu_assert.svh]
// Assertion macros for the mixed fraction ALU
`ifndef MIXED_FRACTION_ALU_ASSERT_SVH
`define MIXED_FRACTION_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
`define MFA_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define MFA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define MFA_ASSERT_IMPLY(label, clk, rst, pre, post)
`define MFA_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[design/mfa_pkg.sv]
// Package: types, operation codes and control structs for the mixed fraction ALU
package mfa_pkg;
   localparam int WHOLE_WIDTH = 16;
   localparam int DEN_WIDTH   = 8;
   localparam int RM_WIDTH    = WHOLE_WIDTH + 1;
   localparam int WIDE_WIDTH  = 2 * DEN_WIDTH;
   localparam int SUM_WIDTH   = WIDE_WIDTH + 2;
   localparam int QUO_WIDTH   = DEN_WIDTH + 1;
   localparam int SHIFT_WIDTH = 3;
   localparam int CNT_WIDTH   = 5;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_EQ  = 3'd2,
      OP_NE  = 3'd3,
      OP_LT  = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]             operation;
      logic [WHOLE_WIDTH-1:0] a_measure;
      logic [DEN_WIDTH-1:0]   a_denominator;
      logic [DEN_WIDTH-1:0]   a_split;
      logic [WHOLE_WIDTH-1:0] b_measure;
      logic [DEN_WIDTH-1:0]   b_denominator;
      logic [DEN_WIDTH-1:0]   b_split;
   } req_type;

   typedef struct packed {
      logic [RM_WIDTH-1:0]   result_measure;
      logic [WIDE_WIDTH-1:0] result_denominator;
      logic [WIDE_WIDTH-1:0] result_split;
      logic                  truth;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic fdiv_load;
      logic fdiv_step;
      logic scale;
      logic combine;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_last;
      logic arith;
   } sts_type;
endpackage

[design/mfa_if.sv]
// Valid/ready channel interface
interface mfa_req_if;
   logic             valid;
   logic             ready;
   mfa_pkg::req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface mfa_rsp_if;
   logic             valid;
   logic             ready;
   mfa_pkg::rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

[design/mfa_datapath.sv]
// Datapath: gcd, lcm scaling, add or subtract, floor division, compares
module mfa_datapath (
   input  logic              clock,
   input  mfa_pkg::req_type  req,
   input  mfa_pkg::cmd_type  cmd,
   output mfa_pkg::sts_type  sts,
   output mfa_pkg::rsp_type  rsp
);
   localparam int DW = mfa_pkg::DEN_WIDTH;
   localparam int WW = mfa_pkg::WIDE_WIDTH;
   localparam int SW = mfa_pkg::SUM_WIDTH;
   localparam int RW = mfa_pkg::RM_WIDTH;
   localparam int QW = mfa_pkg::QUO_WIDTH;
   localparam int KW = mfa_pkg::SHIFT_WIDTH;
   localparam int CW = mfa_pkg::CNT_WIDTH;

   mfa_pkg::req_type r_ff, r_in;
   logic [DW-1:0] da_ff, da_in, db_ff, db_in, gx_ff, gx_in, gy_ff, gy_in, g_ff, g_in;
   logic [KW-1:0] gk_ff, gk_in;
   logic [DW-1:0] fa_ff, fa_in, fb_ff, fb_in, pa_ff, pa_in, pb_ff, pb_in;
   logic [WW-1:0] lcm_ff, lcm_in;
   logic [SW-1:0] rem_ff, rem_in, tot_ff, tot_in;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] da0, db0;
   logic [DW:0]   pa_sh, pb_sh, pa_df, pb_df;
   logic [WW-1:0] sa, sb;
   logic [SW-1:0] mag, rem_sh, diff;
   logic [RW-1:0] wsum;
   logic          is_sub, eq, lt;

   always_comb begin
      da0 = (req.a_denominator == '0) ? DW'(1) : req.a_denominator;
      db0 = (req.b_denominator == '0) ? DW'(1) : req.b_denominator;
   end

   always_comb begin
      r_in = r_ff; da_in = da_ff; db_in = db_ff; gx_in = gx_ff; gy_in = gy_ff;
      g_in = g_ff; gk_in = gk_ff; fa_in = fa_ff; fb_in = fb_ff; pa_in = pa_ff;
      pb_in = pb_ff; lcm_in = lcm_ff; rem_in = rem_ff; tot_in = tot_ff; q_in = q_ff;
      cnt_in = cnt_ff; neg_in = neg_ff;
      is_sub = (r_ff.operation == mfa_pkg::OP_SUB);
      pa_sh = {pa_ff, fa_ff[DW-1]};
      pb_sh = {pb_ff, fb_ff[DW-1]};
      pa_df = pa_sh - {1'b0, g_ff};
      pb_df = pb_sh - {1'b0, g_ff};
      sa = WW'(r_ff.a_split) * WW'(fa_ff);
      sb = WW'(r_ff.b_split) * WW'(fb_ff);
      mag = tot_ff[SW-1] ? SW'(0) - tot_ff : tot_ff;
      rem_sh = {rem_ff[SW-2:0], q_ff[QW-1]};
      diff = rem_sh - SW'(lcm_ff);
      if (cmd.load) begin
         r_in = req; da_in = da0; db_in = db0; gx_in = da0; gy_in = db0;
         gk_in = '0;
      end
      if (cmd.gcd_step) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1; gy_in = gy_ff >> 1; gk_in = gk_ff + KW'(1);
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = (gx_ff - gy_ff) >> 1;
         end else begin
            gy_in = (gy_ff - gx_ff) >> 1;
         end
      end
      if (cmd.fdiv_load) begin
         g_in = DW'((gx_ff | gy_ff) << gk_ff);
         fa_in = db_ff; fb_in = da_ff; pa_in = '0; pb_in = '0;
         cnt_in = CW'(DW);
      end
      if (cmd.fdiv_step) begin
         if (!pa_df[DW]) begin
            pa_in = pa_df[DW-1:0]; fa_in = {fa_ff[DW-2:0], 1'b1};
         end else begin
            pa_in = pa_sh[DW-1:0]; fa_in = {fa_ff[DW-2:0], 1'b0};
         end
         if (!pb_df[DW]) begin
            pb_in = pb_df[DW-1:0]; fb_in = {fb_ff[DW-2:0], 1'b1};
         end else begin
            pb_in = pb_sh[DW-1:0]; fb_in = {fb_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.scale) begin
         lcm_in = WW'(da_ff) * WW'(fa_ff);
         tot_in = is_sub ? SW'(sa) - SW'(sb) : SW'(sa) + SW'(sb);
      end
      if (cmd.combine) begin
         neg_in = tot_ff[SW-1];
         rem_in = SW'(mag[SW-2:QW]);
         q_in = mag[QW-1:0];
         cnt_in = CW'(QW);
      end
      if (cmd.div_step) begin
         if (!diff[SW-1]) begin
            rem_in = diff; q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh; q_in = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.finish && neg_ff && rem_ff != '0) begin
         rem_in = SW'(lcm_ff) - rem_ff;
         q_in = q_ff + QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; da_ff <= da_in; db_ff <= db_in; gx_ff <= gx_in; gy_ff <= gy_in;
      g_ff <= g_in; gk_ff <= gk_in; fa_ff <= fa_in; fb_ff <= fb_in; pa_ff <= pa_in;
      pb_ff <= pb_in; lcm_ff <= lcm_in; rem_ff <= rem_in; tot_ff <= tot_in;
      q_ff <= q_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
   end

   always_comb begin
      sts.gcd_done = (gx_ff == '0) || (gy_ff == '0);
      sts.div_last = (cnt_ff == CW'(1));
      sts.arith = (r_ff.operation == mfa_pkg::OP_ADD) ||
                  (r_ff.operation == mfa_pkg::OP_SUB);
      eq = (r_ff.a_measure == r_ff.b_measure) &&
           (r_ff.a_denominator == r_ff.b_denominator) && (r_ff.a_split == r_ff.b_split);
      if (r_ff.a_measure != r_ff.b_measure)
         lt = $signed(r_ff.a_measure) < $signed(r_ff.b_measure);
      else
         lt = (WW'(r_ff.a_split) * WW'(db_ff)) < (WW'(r_ff.b_split) * WW'(da_ff));
      if (r_ff.operation == mfa_pkg::OP_SUB)
         wsum = RW'($signed(r_ff.a_measure)) - RW'($signed(r_ff.b_measure));
      else
         wsum = RW'($signed(r_ff.a_measure)) + RW'($signed(r_ff.b_measure));
      rsp = '0;
      case (r_ff.operation)
         mfa_pkg::OP_ADD, mfa_pkg::OP_SUB: begin
            rsp.result_measure     = neg_ff ? wsum - RW'(q_ff) : wsum + RW'(q_ff);
            rsp.result_denominator = lcm_ff;
            rsp.result_split       = WW'(rem_ff);
         end
         mfa_pkg::OP_EQ: rsp.truth = eq;
         mfa_pkg::OP_NE: rsp.truth = !eq;
         mfa_pkg::OP_LT: rsp.truth = lt;
         default: rsp = '0;
      endcase
   end
endmodule

[design/mfa_control.sv]
// Controller: sequences load, gcd, scale, divide and result transfer
`include "mixed_fraction_alu_assert.svh"
module mfa_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mfa_pkg::sts_type sts,
   output mfa_pkg::cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_GCD  = 8'b00000010,
      S_FDV  = 8'b00000100,
      S_SCL  = 8'b00001000,
      S_CMB  = 8'b00010000,
      S_DIV  = 8'b00100000,
      S_FIN  = 8'b01000000,
      S_OUT  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1; state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (!sts.arith) begin
               state_in = S_OUT;
            end else if (sts.gcd_done) begin
               cmd.fdiv_load = 1'b1; state_in = S_FDV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_FDV: begin
            cmd.fdiv_step = 1'b1;
            if (sts.div_last) state_in = S_SCL;
         end
         S_SCL: begin cmd.scale = 1'b1; state_in = S_CMB; end
         S_CMB: begin cmd.combine = 1'b1; state_in = S_DIV; end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_FIN;
         end
         S_FIN: begin cmd.finish = 1'b1; state_in = S_OUT; end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `MFA_ASSERT_IMPLY(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `MFA_ASSERT_IMPLY(a_excl, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `MFA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MFA_ASSERT_NEXT(a_take, clock, reset, req_valid && req_ready, !req_ready)
endmodule

[design/mixed_fraction_alu.sv]
// Top level: mixed number add, subtract and compare unit
//  channel | dir | payload
//  req     | in  | operation, a/b measure, denominator, split
//  rsp     | out | result_measure, result_denominator, result_split, truth
//  Add/subtract: after the request transfer the controller runs binary gcd steps,
//  8 factor divide steps, the scale and combine states, 9 quotient steps and the finish state.
//  Compares and unused codes: the result is presented straight after the gcd state, with no steps.
//  One item at a time; the request side reopens in the cycle after the result transfer.
//  Synchronous active-high reset returns the controller to idle.
//  A stalled result holds until transferred; no new item is taken meanwhile.
module mixed_fraction_alu (
   input logic       clock,
   input logic       reset,
   mfa_req_if.sink   req,
   mfa_rsp_if.source rsp
);
   mfa_pkg::cmd_type cmd;
   mfa_pkg::sts_type sts;

   mfa_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .sts(sts), .cmd(cmd)
   );

   mfa_datapath u_dp (
      .clock(clock), .req(req.payload), .cmd(cmd), .sts(sts), .rsp(rsp.payload)
   );
endmodule

[test/tb.sv]
// Testbench for the mixed fraction ALU: queued driver, monitor and built-in predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfa_req_if req();
   mfa_rsp_if rsp();

   mixed_fraction_alu dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #2 clock = ~clock;

   mfa_pkg::req_type pending_q[$];
   mfa_pkg::rsp_type expected_q[$];
   int      send_idle_pct = 24;
   int      recv_idle_pct = 79;
   int      mismatches = 0;
   bit      stimulus_done = 1'b0;

   function automatic longint gcd_of(longint x, longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic mfa_pkg::rsp_type mixed_result(mfa_pkg::req_type r);
      mfa_pkg::rsp_type o;
      longint      am, bm, sa, sb, total, q, rem, meas, lcm;
      longint      da, db;
      bit          eq;
      o = '0;
      am = longint'($signed(r.a_measure));
      bm = longint'($signed(r.b_measure));
      da = (r.a_denominator == 0) ? 1 : r.a_denominator;
      db = (r.b_denominator == 0) ? 1 : r.b_denominator;
      case (r.operation)
         mfa_pkg::OP_ADD, mfa_pkg::OP_SUB: begin
            lcm = da;
            sa = r.a_split;
            sb = r.b_split;
            if (da != db) begin
               lcm = (da / gcd_of(da, db)) * db;
               sa = r.a_split * (lcm / da);
               sb = r.b_split * (lcm / db);
            end
            if (r.operation == mfa_pkg::OP_ADD) begin
               meas = am + bm;
               total = sa + sb;
            end else begin
               meas = am - bm;
               total = sa - sb;
            end
            q = total / lcm;
            rem = total % lcm;
            if (rem < 0) begin
               rem += lcm;
               q -= 1;
            end
            meas += q;
            o.result_measure = meas[16:0];
            o.result_denominator = lcm[15:0];
            o.result_split = rem[15:0];
         end
         mfa_pkg::OP_EQ, mfa_pkg::OP_NE: begin
            eq = (r.a_measure == r.b_measure) && (r.a_denominator == r.b_denominator)
                 && (r.a_split == r.b_split);
            o.truth = (r.operation == mfa_pkg::OP_EQ) ? eq : !eq;
         end
         mfa_pkg::OP_LT: begin
            if (am == bm)
               o.truth = (r.a_split * db) < (r.b_split * da);
            else
               o.truth = am < bm;
         end
         default: o = '0;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
      end else if (!req.valid || req.ready) begin
         if (req.valid)
            expected_q.push_back(mixed_result(req.payload));
         if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid <= 1'b1;
            req.payload <= pending_q.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: %p", rsp.payload);
            end else if (rsp.payload !== expected_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", expected_q[0], rsp.payload);
               void'(expected_q.pop_front());
            end else begin
               void'(expected_q.pop_front());
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic mfa_pkg::req_type random_item(bit wellformed);
      mfa_pkg::req_type r;
      r.operation = wellformed ? 3'($urandom_range(4)) : 3'($urandom_range(7));
      r.a_measure = 16'($urandom);
      r.b_measure = ($urandom_range(3) == 0) ? r.a_measure : 16'($urandom);
      r.a_denominator = 8'($urandom);
      r.b_denominator = ($urandom_range(3) == 0) ? r.a_denominator : 8'($urandom);
      if (wellformed) begin
         if (r.a_denominator == 0) r.a_denominator = 8'd1;
         if (r.b_denominator == 0) r.b_denominator = 8'd1;
         r.a_split = 8'($urandom_range(r.a_denominator - 1));
         r.b_split = 8'($urandom_range(r.b_denominator - 1));
      end else begin
         r.a_split = 8'($urandom);
         r.b_split = 8'($urandom);
      end
      if ($urandom_range(7) == 0) begin
         r.b_split = r.a_split;
         r.b_measure = r.a_measure;
      end
      return r;
   endfunction

   function automatic mfa_pkg::req_type make_item(logic [2:0] op, logic [15:0] am,
                                                  logic [7:0] ad, logic [7:0] as,
                                                  logic [15:0] bm, logic [7:0] bd,
                                                  logic [7:0] bs);
      return '{op, am, ad, as, bm, bd, bs};
   endfunction

   task automatic wait_drained();
      while (pending_q.size() > 0 || req.valid || expected_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      pending_q.push_back(make_item(mfa_pkg::OP_ADD, 16'h7fff, 8'd255, 8'd254,
                                    16'h7fff, 8'd254, 8'd253));
      pending_q.push_back(make_item(mfa_pkg::OP_ADD, 16'h8000, 8'd1, 8'd0,
                                    16'h8000, 8'd1, 8'd0));
      pending_q.push_back(make_item(mfa_pkg::OP_SUB, 16'h8000, 8'd3, 8'd0,
                                    16'h7fff, 8'd5, 8'd4));
      pending_q.push_back(make_item(mfa_pkg::OP_SUB, 16'h7fff, 8'd255, 8'd254,
                                    16'h8000, 8'd1, 8'd0));
      pending_q.push_back(make_item(mfa_pkg::OP_ADD, 16'd1, 8'd4, 8'd2, 16'd2, 8'd4, 8'd3));
      pending_q.push_back(make_item(mfa_pkg::OP_ADD, 16'd0, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0));
      pending_q.push_back(make_item(mfa_pkg::OP_SUB, 16'd5, 8'd0, 8'd0, 16'd1, 8'd7, 8'd3));
      pending_q.push_back(make_item(mfa_pkg::OP_ADD, 16'd3, 8'd2, 8'd255,
                                    16'd1, 8'd3, 8'd200));
      pending_q.push_back(make_item(mfa_pkg::OP_SUB, 16'd0, 8'd9, 8'd1, 16'd0, 8'd5, 8'd255));
      pending_q.push_back(make_item(mfa_pkg::OP_EQ, 16'd4, 8'd6, 8'd2, 16'd4, 8'd6, 8'd2));
      pending_q.push_back(make_item(mfa_pkg::OP_EQ, 16'd4, 8'd0, 8'd2, 16'd4, 8'd1, 8'd2));
      pending_q.push_back(make_item(mfa_pkg::OP_NE, 16'hffff, 8'd6, 8'd2,
                                    16'hffff, 8'd6, 8'd2));
      pending_q.push_back(make_item(mfa_pkg::OP_NE, 16'd4, 8'd6, 8'd2, 16'd4, 8'd3, 8'd1));
      pending_q.push_back(make_item(mfa_pkg::OP_LT, 16'h8000, 8'd1, 8'd0,
                                    16'h7fff, 8'd1, 8'd0));
      pending_q.push_back(make_item(mfa_pkg::OP_LT, 16'd7, 8'd6, 8'd2, 16'd7, 8'd3, 8'd1));
      pending_q.push_back(make_item(mfa_pkg::OP_LT, 16'd7, 8'd255, 8'd1,
                                    16'd7, 8'd254, 8'd1));
      pending_q.push_back(make_item(mfa_pkg::OP_LT, 16'd7, 8'd0, 8'd0, 16'd7, 8'd0, 8'd255));
      pending_q.push_back(make_item(3'd5, 16'd1, 8'd2, 8'd1, 16'd1, 8'd2, 8'd1));
      pending_q.push_back(make_item(3'd7, 16'hffff, 8'hff, 8'hff, 16'hffff, 8'hff, 8'hff));
      pending_q.push_back(make_item(mfa_pkg::OP_ADD, 16'hffff, 8'd251, 8'd250,
                                    16'hffff, 8'd241, 8'd240));
      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 24 : 0;
         for (int i = 0; i < 250; i++)
            pending_q.push_back(random_item($urandom_range(9) != 0));
      end
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
